// ===== src/ssc_pkg.sv =====
// shared constants, word types and stage numbering for the segment pair closest points core
// no dependencies
package ssc_pkg;

    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;
    localparam int PAR_W   = 32;
    localparam int EPS_W   = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int DOT_W   = PROD_W + 2;
    localparam int HALF_W  = DOT_W / 2;
    localparam int WIDE_W  = 2 * DOT_W;
    localparam int DW      = WIDE_W + 1;
    localparam int PM_W    = DIFF_W + PAR_W + 2;
    localparam int SH_W    = PM_W - PAR_W + 1;
    localparam int SUM_W   = SH_W + 1;

    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

    localparam int MUL_LAT = 4;
    localparam int DIV_LAT = PAR_W + 1;

    // register stage numbers along the pipe
    localparam int ST_DOT  = 3;
    localparam int ST_FLAG = ST_DOT + 1;
    localparam int ST_MUL1 = ST_DOT + MUL_LAT;
    localparam int ST_DEN  = ST_MUL1 + 1;
    localparam int ST_S1   = ST_DEN + DIV_LAT;
    localparam int ST_BS   = ST_S1 + MUL_LAT;
    localparam int ST_TN   = ST_BS + 1;
    localparam int ST_SEL  = ST_TN + 1;
    localparam int ST_Q2   = ST_SEL + DIV_LAT;
    localparam int ST_PROD = ST_Q2 + 1;
    localparam int ST_OUT  = ST_PROD + 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] seg1_start_x;
        logic signed [COORD_W-1:0] seg1_start_y;
        logic signed [COORD_W-1:0] seg1_start_z;
        logic signed [COORD_W-1:0] seg1_end_x;
        logic signed [COORD_W-1:0] seg1_end_y;
        logic signed [COORD_W-1:0] seg1_end_z;
        logic signed [COORD_W-1:0] seg2_start_x;
        logic signed [COORD_W-1:0] seg2_start_y;
        logic signed [COORD_W-1:0] seg2_start_z;
        logic signed [COORD_W-1:0] seg2_end_x;
        logic signed [COORD_W-1:0] seg2_end_y;
        logic signed [COORD_W-1:0] seg2_end_z;
    } in_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] closest_on_first_x;
        logic signed [COORD_W-1:0] closest_on_first_y;
        logic signed [COORD_W-1:0] closest_on_first_z;
        logic signed [COORD_W-1:0] closest_on_second_x;
        logic signed [COORD_W-1:0] closest_on_second_y;
        logic signed [COORD_W-1:0] closest_on_second_z;
    } out_word_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] p1;
        logic [2:0][COORD_W-1:0] p2;
        logic [2:0][DIFF_W-1:0]  d1;
        logic [2:0][DIFF_W-1:0]  d2;
    } geo_t;

    typedef struct packed {
        logic [DOT_W-1:0] a;
        logic [DOT_W-1:0] b;
        logic [DOT_W-1:0] c;
        logic [DOT_W-1:0] e;
        logic [DOT_W-1:0] f;
        logic             deg1;
        logic             deg2;
    } dot_t;

    typedef struct packed {
        logic           to_t;
        logic [PAR_W:0] fixed;
    } sel_t;

endpackage

// ===== src/ssc_in_if.sv =====
// input channel of the closest points core: one segment pair per word
// depends on ssc_pkg
interface ssc_in_if import ssc_pkg::*; ();
    logic     valid;
    logic     ready;
    in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/ssc_out_if.sv =====
// output channel of the closest points core: two closest points per word
// depends on ssc_pkg
interface ssc_out_if import ssc_pkg::*; ();
    logic      valid;
    logic      ready;
    out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/segment_segment_closest_points_core.sv =====
// top level of the segment pair closest points core
// depends on ssc_pkg, ssc_in_if, ssc_out_if, ssc_mul, ssc_div
//
// usage:
// pairs carries one word per segment pair: both end points of each segment,
// signed Q16.16. points returns one word per pair: the closest point on each
// segment, Q16.16, saturated. words leave in the order they came in.
// cfg_we/cfg_wdata write the degeneracy epsilon (reset value 1); write it only
// while no word is in flight.
// one word per cycle is taken and delivered while the pipe is not held; the
// pipe has 82 register stages, with two 33-stage pipelined dividers and
// five 4-stage wide multipliers among them.
// reset clears all valid bits and sets epsilon to 1.
// when points.ready is low with a word waiting, the whole pipe holds and
// pairs.ready drops; nothing is lost or repeated.
module segment_segment_closest_points_core import ssc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    ssc_in_if.sink           pairs,
    ssc_out_if.source        points,
    input  logic             cfg_we,
    input  logic [EPS_W-1:0] cfg_wdata
);

    logic [EPS_W-1:0]          eps_reg;
    logic                      adv;
    logic [ST_OUT:1]           valid_reg;

    geo_t                      geo_next;
    geo_t                      geo_reg [1:ST_PROD];
    logic [2:0][DIFF_W-1:0]    r_next;
    logic [2:0][DIFF_W-1:0]    r_reg;
    logic [2:0][COORD_W-1:0]   p1_in, q1_in, p2_in, q2_in;

    logic signed [PROD_W-1:0]  prod_next [5][3];
    logic signed [PROD_W-1:0]  prod_reg  [5][3];

    dot_t                      dot_next;
    dot_t                      dot_flag;
    dot_t                      dot_reg [ST_DOT:ST_TN];
    logic signed [DOT_W-1:0]   eps_len;

    logic signed [WIDE_W-1:0]  ae, bb, bf, ce, bs;
    logic signed [DW-1:0]      den_reg, num_reg, eps_den, div1_n;
    logic [PAR_W:0]            s1;
    logic [PAR_W:0]            s1_reg [ST_S1+1:ST_TN];
    logic signed [DW-1:0]      tn_reg;

    logic signed [DW-1:0]      a_w, b_w, c_w, e_w, f_w, td;
    logic signed [DW-1:0]      n2_next, d2_next, n2_reg, d2_reg;
    sel_t                      sel_next;
    sel_t                      sel_reg [ST_SEL:ST_Q2];
    logic [PAR_W:0]            q2, s_fin, t_fin;

    logic signed [PM_W-1:0]    pm_next [2][3];
    logic signed [PM_W-1:0]    pm_reg  [2][3];
    logic [PM_W:0]             rnd     [2][3];
    logic signed [SUM_W-1:0]   xs      [2][3];
    logic [2:0][COORD_W-1:0]   res     [2];
    logic signed [SUM_W-1:0]   cmax, cmin;
    out_word_t                 out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
        end
        else if (cfg_we)
        begin
            eps_reg <= cfg_wdata;
        end
    end

    assign adv         = !valid_reg[ST_OUT] || points.ready;
    assign pairs.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[ST_OUT-1:1], pairs.valid};
        end
    end

    // differences
    always_comb
    begin
        p1_in[0] = pairs.data.seg1_start_x;
        p1_in[1] = pairs.data.seg1_start_y;
        p1_in[2] = pairs.data.seg1_start_z;
        q1_in[0] = pairs.data.seg1_end_x;
        q1_in[1] = pairs.data.seg1_end_y;
        q1_in[2] = pairs.data.seg1_end_z;
        p2_in[0] = pairs.data.seg2_start_x;
        p2_in[1] = pairs.data.seg2_start_y;
        p2_in[2] = pairs.data.seg2_start_z;
        q2_in[0] = pairs.data.seg2_end_x;
        q2_in[1] = pairs.data.seg2_end_y;
        q2_in[2] = pairs.data.seg2_end_z;
        for (int i = 0; i < 3; i++)
        begin
            geo_next.p1[i] = p1_in[i];
            geo_next.p2[i] = p2_in[i];
            geo_next.d1[i] = {q1_in[i][COORD_W-1], q1_in[i]} - {p1_in[i][COORD_W-1], p1_in[i]};
            geo_next.d2[i] = {q2_in[i][COORD_W-1], q2_in[i]} - {p2_in[i][COORD_W-1], p2_in[i]};
            r_next[i]      = {p1_in[i][COORD_W-1], p1_in[i]} - {p2_in[i][COORD_W-1], p2_in[i]};
        end
    end

    // coordinate products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[0][i] = $signed(geo_reg[1].d1[i]) * $signed(geo_reg[1].d1[i]);
            prod_next[1][i] = $signed(geo_reg[1].d2[i]) * $signed(geo_reg[1].d2[i]);
            prod_next[2][i] = $signed(geo_reg[1].d1[i]) * $signed(geo_reg[1].d2[i]);
            prod_next[3][i] = $signed(geo_reg[1].d1[i]) * $signed(r_reg[i]);
            prod_next[4][i] = $signed(geo_reg[1].d2[i]) * $signed(r_reg[i]);
        end
    end

    // dot products
    always_comb
    begin
        dot_next.a    = DOT_W'(prod_reg[0][0]) + DOT_W'(prod_reg[0][1]) + DOT_W'(prod_reg[0][2]);
        dot_next.e    = DOT_W'(prod_reg[1][0]) + DOT_W'(prod_reg[1][1]) + DOT_W'(prod_reg[1][2]);
        dot_next.b    = DOT_W'(prod_reg[2][0]) + DOT_W'(prod_reg[2][1]) + DOT_W'(prod_reg[2][2]);
        dot_next.c    = DOT_W'(prod_reg[3][0]) + DOT_W'(prod_reg[3][1]) + DOT_W'(prod_reg[3][2]);
        dot_next.f    = DOT_W'(prod_reg[4][0]) + DOT_W'(prod_reg[4][1]) + DOT_W'(prod_reg[4][2]);
        dot_next.deg1 = 1'b0;
        dot_next.deg2 = 1'b0;
    end

    assign eps_len = DOT_W'({eps_reg, {FRAC_W{1'b0}}});
    assign eps_den = DW'({eps_reg, {(3 * FRAC_W){1'b0}}});

    // degenerate segment flags
    always_comb
    begin
        dot_flag      = dot_reg[ST_DOT];
        dot_flag.deg1 = $signed(dot_reg[ST_DOT].a) <= eps_len;
        dot_flag.deg2 = $signed(dot_reg[ST_DOT].e) <= eps_len;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            geo_reg[1] <= geo_next;
            r_reg      <= r_next;
            for (int k = 2; k <= ST_PROD; k++)
            begin
                geo_reg[k] <= geo_reg[k-1];
            end
            prod_reg <= prod_next;

            dot_reg[ST_DOT]  <= dot_next;
            dot_reg[ST_FLAG] <= dot_flag;
            for (int k = ST_FLAG + 1; k <= ST_TN; k++)
            begin
                dot_reg[k] <= dot_reg[k-1];
            end

            den_reg <= DW'(ae) - DW'(bb);
            num_reg <= DW'(bf) - DW'(ce);

            s1_reg[ST_S1+1] <= s1;
            for (int k = ST_S1 + 2; k <= ST_TN; k++)
            begin
                s1_reg[k] <= s1_reg[k-1];
            end

            tn_reg <= DW'(bs) + (DW'($signed(dot_reg[ST_BS].f)) <<< PAR_W);

            n2_reg          <= n2_next;
            d2_reg          <= d2_next;
            sel_reg[ST_SEL] <= sel_next;
            for (int k = ST_SEL + 1; k <= ST_Q2; k++)
            begin
                sel_reg[k] <= sel_reg[k-1];
            end

            pm_reg  <= pm_next;
            out_reg <= {res[0][0], res[0][1], res[0][2], res[1][0], res[1][1], res[1][2]};
        end
    end

    ssc_mul u_mul_ae (.clk(clk), .en(adv), .x($signed(dot_reg[ST_DOT].a)),
                      .y($signed(dot_reg[ST_DOT].e)), .p(ae));
    ssc_mul u_mul_bb (.clk(clk), .en(adv), .x($signed(dot_reg[ST_DOT].b)),
                      .y($signed(dot_reg[ST_DOT].b)), .p(bb));
    ssc_mul u_mul_bf (.clk(clk), .en(adv), .x($signed(dot_reg[ST_DOT].b)),
                      .y($signed(dot_reg[ST_DOT].f)), .p(bf));
    ssc_mul u_mul_ce (.clk(clk), .en(adv), .x($signed(dot_reg[ST_DOT].c)),
                      .y($signed(dot_reg[ST_DOT].e)), .p(ce));

    // near parallel pairs give s = 0
    assign div1_n = (den_reg > eps_den) ? num_reg : '0;

    ssc_div u_div_s (.clk(clk), .en(adv), .n(div1_n), .d(den_reg), .q(s1));

    ssc_mul u_mul_bs (.clk(clk), .en(adv), .x($signed(dot_reg[ST_S1].b)),
                      .y($signed(DOT_W'(s1))), .p(bs));

    // case select and second fraction operands
    always_comb
    begin
        a_w = DW'($signed(dot_reg[ST_TN].a));
        b_w = DW'($signed(dot_reg[ST_TN].b));
        c_w = DW'($signed(dot_reg[ST_TN].c));
        e_w = DW'($signed(dot_reg[ST_TN].e));
        f_w = DW'($signed(dot_reg[ST_TN].f));
        td  = e_w <<< PAR_W;
        n2_next        = '0;
        d2_next        = DW'(1);
        sel_next.to_t  = 1'b0;
        sel_next.fixed = '0;
        if (dot_reg[ST_TN].deg1 && dot_reg[ST_TN].deg2)
        begin
            sel_next.to_t = 1'b1;
        end
        else if (dot_reg[ST_TN].deg1)
        begin
            n2_next       = f_w;
            d2_next       = e_w;
            sel_next.to_t = 1'b1;
        end
        else if (dot_reg[ST_TN].deg2 || tn_reg < 0)
        begin
            n2_next = -c_w;
            d2_next = a_w;
        end
        else if (tn_reg > td)
        begin
            n2_next        = b_w - c_w;
            d2_next        = a_w;
            sel_next.fixed = {1'b1, {PAR_W{1'b0}}};
        end
        else
        begin
            n2_next        = tn_reg;
            d2_next        = td;
            sel_next.to_t  = 1'b1;
            sel_next.fixed = s1_reg[ST_TN];
        end
    end

    ssc_div u_div_2 (.clk(clk), .en(adv), .n(n2_reg), .d(d2_reg), .q(q2));

    assign s_fin = sel_reg[ST_Q2].to_t ? sel_reg[ST_Q2].fixed : q2;
    assign t_fin = sel_reg[ST_Q2].to_t ? q2 : sel_reg[ST_Q2].fixed;

    assign cmax = {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    assign cmin = {{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

    // point = start + round(d * param), saturated
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pm_next[0][i] = $signed(geo_reg[ST_Q2].d1[i]) * $signed({1'b0, s_fin});
            pm_next[1][i] = $signed(geo_reg[ST_Q2].d2[i]) * $signed({1'b0, t_fin});
        end
        for (int j = 0; j < 2; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rnd[j][i] = {pm_reg[j][i][PM_W-1], pm_reg[j][i]}
                          + {{(PM_W-PAR_W+1){1'b0}}, 1'b1, {(PAR_W-1){1'b0}}};
                if (j == 0)
                begin
                    xs[j][i] = $signed({rnd[j][i][PM_W], rnd[j][i][PM_W:PAR_W]})
                             + $signed({{(SUM_W-COORD_W){geo_reg[ST_PROD].p1[i][COORD_W-1]}},
                                        geo_reg[ST_PROD].p1[i]});
                end
                else
                begin
                    xs[j][i] = $signed({rnd[j][i][PM_W], rnd[j][i][PM_W:PAR_W]})
                             + $signed({{(SUM_W-COORD_W){geo_reg[ST_PROD].p2[i][COORD_W-1]}},
                                        geo_reg[ST_PROD].p2[i]});
                end
                if (xs[j][i] > cmax)
                begin
                    res[j][i] = {1'b0, {(COORD_W-1){1'b1}}};
                end
                else if (xs[j][i] < cmin)
                begin
                    res[j][i] = {1'b1, {(COORD_W-1){1'b0}}};
                end
                else
                begin
                    res[j][i] = xs[j][i][COORD_W-1:0];
                end
            end
        end
    end

    assign points.valid = valid_reg[ST_OUT];
    assign points.data  = out_reg;

endmodule

// ===== src/ssc_mul.sv =====
// pipelined wide signed multiplier built from four half-width partial products
// depends on ssc_pkg
module ssc_mul import ssc_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [DOT_W-1:0]  x,
    input  logic signed [DOT_W-1:0]  y,
    output logic signed [WIDE_W-1:0] p
);

    logic [DOT_W-1:0]    xm_reg;
    logic [DOT_W-1:0]    ym_reg;
    logic [DOT_W-1:0]    pp_reg [4];
    logic [WIDE_W-1:0]   sum_reg;
    logic [WIDE_W-1:0]   p_reg;
    logic [MUL_LAT-2:0]  neg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xm_reg     <= x[DOT_W-1] ? DOT_W'(-x) : DOT_W'(x);
            ym_reg     <= y[DOT_W-1] ? DOT_W'(-y) : DOT_W'(y);
            neg_reg[0] <= x[DOT_W-1] ^ y[DOT_W-1];

            pp_reg[0]  <= xm_reg[HALF_W-1:0] * ym_reg[HALF_W-1:0];
            pp_reg[1]  <= xm_reg[HALF_W-1:0] * ym_reg[DOT_W-1:HALF_W];
            pp_reg[2]  <= xm_reg[DOT_W-1:HALF_W] * ym_reg[HALF_W-1:0];
            pp_reg[3]  <= xm_reg[DOT_W-1:HALF_W] * ym_reg[DOT_W-1:HALF_W];
            neg_reg[1] <= neg_reg[0];

            sum_reg    <= WIDE_W'(pp_reg[0])
                        + ((WIDE_W'(pp_reg[1]) + WIDE_W'(pp_reg[2])) << HALF_W)
                        + (WIDE_W'(pp_reg[3]) << DOT_W);
            neg_reg[2] <= neg_reg[1];

            p_reg      <= neg_reg[2] ? -sum_reg : sum_reg;
        end
    end

    assign p = $signed(p_reg);

endmodule

// ===== src/ssc_div.sv =====
// pipelined clamped fraction n/d, one quotient bit per stage
// depends on ssc_pkg
module ssc_div import ssc_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [DW-1:0] n,
    input  logic signed [DW-1:0] d,
    output logic [PAR_W:0]       q
);

    logic [WIDE_W-1:0] rem_reg  [PAR_W];
    logic [WIDE_W-1:0] den_reg  [PAR_W];
    logic [PAR_W:0]    q_reg    [PAR_W+1];
    logic              hold_reg [PAR_W];
    logic [WIDE_W:0]   trial    [1:PAR_W];

    always_comb
    begin
        for (int k = 1; k <= PAR_W; k++)
        begin
            trial[k] = {rem_reg[k-1], 1'b0} - {1'b0, den_reg[k-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= n[WIDE_W-1:0];
            den_reg[0] <= d[WIDE_W-1:0];
            if (d <= 0 || n <= 0)
            begin
                hold_reg[0] <= 1'b1;
                q_reg[0]    <= '0;
            end
            else if (n >= d)
            begin
                hold_reg[0] <= 1'b1;
                q_reg[0]    <= {1'b1, {PAR_W{1'b0}}};
            end
            else
            begin
                hold_reg[0] <= 1'b0;
                q_reg[0]    <= '0;
            end

            for (int k = 1; k < PAR_W; k++)
            begin
                den_reg[k]  <= den_reg[k-1];
                hold_reg[k] <= hold_reg[k-1];
                if (hold_reg[k-1])
                begin
                    rem_reg[k] <= rem_reg[k-1];
                end
                else if (!trial[k][WIDE_W])
                begin
                    rem_reg[k] <= trial[k][WIDE_W-1:0];
                end
                else
                begin
                    rem_reg[k] <= {rem_reg[k-1][WIDE_W-2:0], 1'b0};
                end
            end

            for (int k = 1; k <= PAR_W; k++)
            begin
                if (hold_reg[k-1])
                begin
                    q_reg[k] <= q_reg[k-1];
                end
                else
                begin
                    q_reg[k] <= {q_reg[k-1][PAR_W-1:0], !trial[k][WIDE_W]};
                end
            end
        end
    end

    assign q = q_reg[PAR_W];

endmodule
